/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bcdclk_pkg.sv */
package bcdclk_pkg;

    // Operating modes carried with every pin sample
    typedef enum logic [2:0] {
        MODE_RUN       = 3'd0,
        MODE_SET_HTENS = 3'd1,
        MODE_SET_HUNIT = 3'd2,
        MODE_SET_MTENS = 3'd3,
        MODE_SET_MUNIT = 3'd4,
        MODE_SET_STENS = 3'd5,
        MODE_SET_SUNIT = 3'd6,
        MODE_LOAD      = 3'd7
    } t_mode;

    // Upper limits used when a digit is set from the encoder
    localparam logic [3:0] HOUR_TENS_LIMIT = 4'd2;
    localparam logic [3:0] TENS_LIMIT      = 4'd5;
    localparam logic [3:0] UNITS_LIMIT     = 4'd9;

    // Encoder pair reset value (both pins high)
    localparam logic [1:0] ENC_IDLE = 2'b11;

    typedef struct packed {
        logic [2:0] mode;
        logic       square_wave;
        logic       encoder_a;
        logic       encoder_b;
        logic [6:0] load_seconds_bcd;
        logic [6:0] load_minutes_bcd;
        logic [5:0] load_hours_bcd;
    } t_in_item;

    typedef struct packed {
        logic [3:0] seconds_units;
        logic [2:0] seconds_tens;
        logic [3:0] minutes_units;
        logic [2:0] minutes_tens;
        logic [3:0] hours_units;
        logic [2:0] hours_tens;
        logic       rtc_write;
    } t_out_item;

    // Quadrature step for index {previous pair, current pair}
    function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
        logic signed [1:0] q;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: q = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: q = 2'sd1;
            default: q = 2'sd0;
        endcase
        return q;
    endfunction

    // Step a digit by one and clamp it into 0..limit
    function automatic logic [3:0] clamp_step(input logic [3:0] d, input logic up,
                                              input logic [3:0] limit);
        logic [3:0] r;
        if (up) begin
            r = (d >= limit) ? limit : d + 4'd1;
        end else if (d == 4'd0) begin
            r = 4'd0;
        end else begin
            r = (d > limit) ? limit : d - 4'd1;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/bcdclk_core.sv */
`include "assert_macros.svh"

module bcdclk_core import bcdclk_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_data,
    output t_out_item o_result
);

    logic             r_tick,  n_tick;
    logic [1:0]       r_enc,   n_enc;
    logic signed [3:0] r_sum,  n_sum;
    logic [3:0]       r_su, n_su, r_mu, n_mu, r_hu, n_hu;
    logic [2:0]       r_st, n_st, r_mt, n_mt, r_ht, n_ht;
    logic             fired;

    // Work out the next time and encoder state for the item on the input
    always_comb begin
        logic [1:0]        pins;
        logic signed [4:0] sum;
        logic              up;
        logic [3:0]        t4;
        n_tick = r_tick;
        n_enc  = r_enc;
        n_sum  = r_sum;
        n_su = r_su; n_st = r_st; n_mu = r_mu;
        n_mt = r_mt; n_hu = r_hu; n_ht = r_ht;
        fired = 1'b0;
        pins  = {i_data.encoder_b, i_data.encoder_a};
        sum   = 5'sd0;
        up    = 1'b0;
        t4    = 4'd0;
        case (i_data.mode)
            MODE_RUN: begin
                // advance on a rising edge of the tick, carrying in order
                if (i_data.square_wave != r_tick) begin
                    n_tick = i_data.square_wave;
                    if (i_data.square_wave) begin
                        n_su = n_su + 4'd1;
                        if (n_su == 4'd10) begin
                            n_su = 4'd0;
                            n_st = n_st + 3'd1;
                        end
                        if (n_st == 3'd6) begin
                            n_st = 3'd0;
                            n_mu = n_mu + 4'd1;
                        end
                        if (n_mu == 4'd10) begin
                            n_mu = 4'd0;
                            n_mt = n_mt + 3'd1;
                        end
                        if (n_mt == 3'd6) begin
                            n_mt = 3'd0;
                            n_hu = n_hu + 4'd1;
                        end
                        if (n_ht == 3'd2 && n_hu == 4'd4) begin
                            n_hu = 4'd0;
                            n_ht = 3'd0;
                        end
                        if (n_hu == 4'd10) begin
                            n_hu = 4'd0;
                            n_ht = n_ht + 3'd1;
                        end
                    end
                end
            end
            MODE_LOAD: begin
                // take the masked BCD bytes
                n_su = i_data.load_seconds_bcd[3:0];
                n_st = i_data.load_seconds_bcd[6:4];
                n_mu = i_data.load_minutes_bcd[3:0];
                n_mt = i_data.load_minutes_bcd[6:4];
                n_hu = i_data.load_hours_bcd[3:0];
                n_ht = {1'b0, i_data.load_hours_bcd[5:4]};
            end
            default: begin
                // accumulate encoder steps and set the chosen digit past the threshold
                sum   = 5'(r_sum) + 5'(quad_step({r_enc, pins}));
                n_enc = pins;
                n_sum = sum[3:0];
                if (sum > 5'sd3 || sum < -5'sd3) begin
                    fired = 1'b1;
                    up    = (sum > 5'sd3);
                    n_sum = 4'sd0;
                    case (i_data.mode)
                        MODE_SET_HTENS: begin
                            t4   = clamp_step({1'b0, r_ht}, up, HOUR_TENS_LIMIT);
                            n_ht = t4[2:0];
                        end
                        MODE_SET_HUNIT: n_hu = clamp_step(r_hu, up, UNITS_LIMIT);
                        MODE_SET_MTENS: begin
                            t4   = clamp_step({1'b0, r_mt}, up, TENS_LIMIT);
                            n_mt = t4[2:0];
                        end
                        MODE_SET_MUNIT: n_mu = clamp_step(r_mu, up, UNITS_LIMIT);
                        MODE_SET_STENS: begin
                            t4   = clamp_step({1'b0, r_st}, up, TENS_LIMIT);
                            n_st = t4[2:0];
                        end
                        MODE_SET_SUNIT: n_su = clamp_step(r_su, up, UNITS_LIMIT);
                        default: ;
                    endcase
                end
            end
        endcase
    end

    // Hold the time and encoder state, advance on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= 1'b0;
            r_enc  <= ENC_IDLE;
            r_sum  <= 4'sd0;
            r_su <= 4'd0; r_st <= 3'd0; r_mu <= 4'd0;
            r_mt <= 3'd0; r_hu <= 4'd0; r_ht <= 3'd0;
        end else if (i_accept) begin
            r_tick <= n_tick;
            r_enc  <= n_enc;
            r_sum  <= n_sum;
            r_su <= n_su; r_st <= n_st; r_mu <= n_mu;
            r_mt <= n_mt; r_hu <= n_hu; r_ht <= n_ht;
        end
    end

    // Result is the time after this item
    assign o_result = '{seconds_units: n_su, seconds_tens: n_st,
                        minutes_units: n_mu, minutes_tens: n_mt,
                        hours_units: n_hu, hours_tens: n_ht,
                        rtc_write: fired};

    `ASSERT_IMPL(a_sum_range, i_clk, i_rst_n, 1'b1,
        (r_sum <= 4'sd3) && (r_sum >= -4'sd3), "encoder accumulator out of range")
    `ASSERT_NEXT(a_load_digits, i_clk, i_rst_n, i_accept && (i_data.mode == MODE_LOAD),
        (r_su == $past(i_data.load_seconds_bcd[3:0])) &&
        (r_mt == $past(i_data.load_minutes_bcd[6:4])), "load did not take the BCD bytes")

endmodule

/* hw/rtl/bcdclk_out_buf.sv */
`include "assert_macros.svh"

module bcdclk_out_buf import bcdclk_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_out_item i_result,
    output logic      o_full,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    logic      r_out_valid, r_skid_valid;
    t_out_item r_out, r_skid;
    logic      take;

    assign take = r_out_valid && !i_stall;

    // Valid flags: refill the output stage from skid first, else from the new item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            r_out_valid  <= r_skid_valid || i_accept;
            r_skid_valid <= 1'b0;
        end else if (i_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            r_out <= r_skid_valid ? r_skid : i_result;
        end else if (i_accept) begin
            r_skid <= i_result;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `ASSERT_IMPL(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid,
        "skid stage holds an item while the output stage is empty")
    `ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && take,
        r_out_valid && !r_skid_valid && (r_out == $past(r_skid)),
        "skid item not moved to the output stage")

endmodule

/* hw/rtl/bcd_clock_with_encoder_set.sv */
// BCD 24-hour time-of-day counter, set from a quadrature encoder.
// Input channel: i_in_valid / o_in_stall with i_in_data, one pin sample and
// a mode per transfer. Mode 0 runs the clock on rising edges of the 1 Hz
// wave, modes 1 to 6 set one digit from the encoder, mode 7 loads BCD bytes.
// Output channel: o_out_valid / i_out_stall with o_out_data, exactly one
// result per input transfer: the six digits after the step and rtc_write.
// Each result is registered in the output register, or in the skid register
// when the output stage is held. Throughput: one item per cycle while
// o_in_stall is low; each step is one pass of logic from the state registers.
// Stall: an output register and a skid register hold up to two results;
// o_in_stall rises only when both are full, and is itself registered.
// Reset (synchronous, i_rst_n low): time 00:00:00, accumulator cleared,
// encoder pair taken as both high, tick level low, both stages empty.
module bcd_clock_with_encoder_set import bcdclk_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic      accept;
    logic      buf_full;
    t_out_item result;

    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    bcdclk_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_data   (i_in_data),
        .o_result (result)
    );

    bcdclk_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_result (result),
        .o_full   (buf_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_data   (o_out_data)
    );

endmodule

/* verif/tb_bcd_clock_with_encoder_set.sv */
`timescale 1ns / 1ps

module tb_bcd_clock_with_encoder_set;
    import bcdclk_pkg::*;

    localparam int WATCHDOG_CYCLES = 1000;
    localparam int PHASE_ITEMS     = 300;
    localparam int NUM_PHASES      = 5;
    localparam int LONG_HOLD       = 60;
    // Idle and stall odds per phase; the last phase adds the long receiver hold
    localparam int SEND_IDLE_PCT [NUM_PHASES]  = '{0, 56, 0, 27, 0};
    localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 56, 27, 0};
    // Accumulator delta for {previous pin pair, current pin pair}
    localparam int ENC_TRANSITION_DELTA [16] =
        '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    bcd_clock_with_encoder_set i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // Pin samples waiting to be driven, and time readings awaiting the block
    t_in_item  pending_samples [$];
    t_out_item expected_readings [$];

    // Predicted clock state
    logic       wave_seen  = 1'b0;
    logic [1:0] pins_seen  = ENC_IDLE;
    int         turn_count = 0;
    logic [3:0] sec_u      = '0;
    logic [2:0] sec_t      = '0;
    logic [3:0] min_u      = '0;
    logic [2:0] min_t      = '0;
    logic [3:0] hour_u     = '0;
    logic [2:0] hour_t     = '0;

    // Stimulus generator tracking
    logic       gen_wave   = 1'b0;
    logic [1:0] gen_pins   = ENC_IDLE;
    int         samples_queued = 0;

    // Handshake and bookkeeping
    bit in_accepted       = 1'b0;
    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;
    int long_holds_wanted = 0;
    int long_holds_done   = 0;
    int hold_left         = 0;
    int idle_cycles       = 0;
    int mismatches        = 0;
    int results_checked   = 0;
    int set_steps         = 0;
    int loads_seen        = 0;

    function automatic int clamp_digit(int d, int delta, int limit);
        int v;
        v = d + delta;
        if (v > limit) v = limit;
        if (v < 0) v = 0;
        return v;
    endfunction

    // Apply one pin sample to the predicted clock and return the reading after it
    function automatic t_out_item predict_clock_step(t_in_item smp);
        t_out_item  r;
        logic [1:0] pins;
        int         sum;
        int         delta;
        pins  = {smp.encoder_b, smp.encoder_a};
        delta = 0;
        r.rtc_write = 1'b0;
        case (t_mode'(smp.mode))
            MODE_RUN: begin
                // advance on a rising tick; carries test each digit after its step
                if (smp.square_wave != wave_seen) begin
                    wave_seen = smp.square_wave;
                    if (smp.square_wave) begin
                        sec_u = sec_u + 4'd1;
                        if (sec_u == 4'd10) begin
                            sec_u = '0;
                            sec_t = sec_t + 3'd1;
                        end
                        if (sec_t == 3'd6) begin
                            sec_t = '0;
                            min_u = min_u + 4'd1;
                        end
                        if (min_u == 4'd10) begin
                            min_u = '0;
                            min_t = min_t + 3'd1;
                        end
                        if (min_t == 3'd6) begin
                            min_t = '0;
                            hour_u = hour_u + 4'd1;
                        end
                        if (hour_t == 3'd2 && hour_u == 4'd4) begin
                            hour_u = '0;
                            hour_t = '0;
                        end
                        if (hour_u == 4'd10) begin
                            hour_u = '0;
                            hour_t = hour_t + 3'd1;
                        end
                    end
                end
            end
            MODE_LOAD: begin
                sec_u  = smp.load_seconds_bcd[3:0];
                sec_t  = smp.load_seconds_bcd[6:4];
                min_u  = smp.load_minutes_bcd[3:0];
                min_t  = smp.load_minutes_bcd[6:4];
                hour_u = smp.load_hours_bcd[3:0];
                hour_t = {1'b0, smp.load_hours_bcd[5:4]};
            end
            default: begin
                // accumulate encoder transitions; step the chosen digit past +/-3
                sum = turn_count + ENC_TRANSITION_DELTA[{pins_seen, pins}];
                pins_seen = pins;
                if (sum > 3) delta = 1;
                else if (sum < -3) delta = -1;
                if (delta != 0) begin
                    r.rtc_write = 1'b1;
                    sum = 0;
                    case (t_mode'(smp.mode))
                        MODE_SET_HTENS: hour_t = 3'(clamp_digit(hour_t, delta, HOUR_TENS_LIMIT));
                        MODE_SET_HUNIT: hour_u = 4'(clamp_digit(hour_u, delta, UNITS_LIMIT));
                        MODE_SET_MTENS: min_t  = 3'(clamp_digit(min_t, delta, TENS_LIMIT));
                        MODE_SET_MUNIT: min_u  = 4'(clamp_digit(min_u, delta, UNITS_LIMIT));
                        MODE_SET_STENS: sec_t  = 3'(clamp_digit(sec_t, delta, TENS_LIMIT));
                        MODE_SET_SUNIT: sec_u  = 4'(clamp_digit(sec_u, delta, UNITS_LIMIT));
                        default: ;
                    endcase
                end
                turn_count = sum;
            end
        endcase
        r.seconds_units = sec_u;
        r.seconds_tens  = sec_t;
        r.minutes_units = min_u;
        r.minutes_tens  = min_t;
        r.hours_units   = hour_u;
        r.hours_tens    = hour_t;
        return r;
    endfunction

    task automatic queue_sample(t_mode m, logic wave, logic [1:0] pins,
                                logic [6:0] s, logic [6:0] mn, logic [5:0] h);
        t_in_item smp;
        smp.mode             = m;
        smp.square_wave      = wave;
        smp.encoder_a        = pins[0];
        smp.encoder_b        = pins[1];
        smp.load_seconds_bcd = s;
        smp.load_minutes_bcd = mn;
        smp.load_hours_bcd   = h;
        pending_samples.push_back(smp);
        samples_queued++;
        // track what the block will remember, so sequences stay well formed
        if (m == MODE_RUN) gen_wave = wave;
        else if (m != MODE_LOAD) gen_pins = pins;
    endtask

    // Queue one full encoder detent: four Gray steps in one direction
    task automatic queue_detent(t_mode m, bit up);
        logic [1:0] nxt;
        repeat (4) begin
            if (up) begin
                case (gen_pins)
                    2'b11:   nxt = 2'b01;
                    2'b01:   nxt = 2'b00;
                    2'b00:   nxt = 2'b10;
                    default: nxt = 2'b11;
                endcase
            end else begin
                case (gen_pins)
                    2'b11:   nxt = 2'b10;
                    2'b10:   nxt = 2'b00;
                    2'b00:   nxt = 2'b01;
                    default: nxt = 2'b11;
                endcase
            end
            queue_sample(m, 1'($urandom), nxt, 7'($urandom), 7'($urandom), 6'($urandom));
        end
    endtask

    function automatic logic [7:0] to_bcd(int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // Queue a random mix of loads, tick runs, set turns and noise
    task automatic queue_random_phase(int count);
        int         stop_at;
        int         r;
        int         n;
        logic [7:0] s;
        logic [7:0] mn;
        logic [7:0] h;
        t_mode      m;
        bit         up;
        stop_at = samples_queued + count;
        while (samples_queued < stop_at) begin
            r = $urandom_range(99);
            if (r < 30) begin
                // load a time, mostly valid and near a carry, then run ticks over it
                if ($urandom_range(4) == 0) begin
                    s  = 8'($urandom);
                    mn = 8'($urandom);
                    h  = 8'($urandom);
                end else begin
                    s  = to_bcd($urandom_range(1) ? $urandom_range(50, 59) : $urandom_range(59));
                    mn = to_bcd($urandom_range(1) ? 59 : $urandom_range(59));
                    case ($urandom_range(3))
                        0:       h = to_bcd(23);
                        1:       h = to_bcd(9);
                        2:       h = to_bcd(19);
                        default: h = to_bcd($urandom_range(23));
                    endcase
                end
                queue_sample(MODE_LOAD, 1'($urandom), 2'($urandom), s[6:0], mn[6:0], h[5:0]);
                n = $urandom_range(2, 30);
                repeat (n) begin
                    queue_sample(MODE_RUN, ($urandom_range(9) == 0) ? gen_wave : ~gen_wave,
                                 2'($urandom), 7'($urandom), 7'($urandom), 6'($urandom));
                end
            end else if (r < 70) begin
                // turn the encoder on one digit, with the odd stray pin sample
                m  = t_mode'(3'($urandom_range(1, 6)));
                up = 1'($urandom);
                n  = $urandom_range(1, 5);
                repeat (n) begin
                    if ($urandom_range(9) == 0) begin
                        queue_sample(m, 1'($urandom), 2'($urandom),
                                     7'($urandom), 7'($urandom), 6'($urandom));
                    end
                    if ($urandom_range(4) == 0) up = ~up;
                    queue_detent(m, up);
                end
            end else if (r < 85) begin
                n = $urandom_range(2, 20);
                repeat (n) begin
                    queue_sample(MODE_RUN, ~gen_wave, 2'($urandom),
                                 7'($urandom), 7'($urandom), 6'($urandom));
                end
            end else begin
                n = $urandom_range(1, 5);
                repeat (n) begin
                    queue_sample(t_mode'(3'($urandom)), 1'($urandom), 2'($urandom),
                                 7'($urandom), 7'($urandom), 6'($urandom));
                end
            end
        end
    endtask

    // Hold until every queued sample has been sent and answered
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (pending_samples.size() != 0 || i_in_valid || expected_readings.size() != 0);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Driver: offer the next sample once the current one has transferred
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_accepted) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pending_samples.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus long holds counted here
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (long_holds_done != long_holds_wanted) begin
            long_holds_done <= long_holds_done + 1;
            hold_left       <= LONG_HOLD;
            i_out_stall     <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: check results first, then predict for the sample just taken
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        bit        moved;
        moved       = 1'b0;
        in_accepted = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (expected_readings.size() == 0) begin
                    $display("%0t: result with none expected, actual %p", $time, o_out_data);
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("seconds_units", want.seconds_units, o_out_data.seconds_units);
                    check_field("seconds_tens", want.seconds_tens, o_out_data.seconds_tens);
                    check_field("minutes_units", want.minutes_units, o_out_data.minutes_units);
                    check_field("minutes_tens", want.minutes_tens, o_out_data.minutes_tens);
                    check_field("hours_units", want.hours_units, o_out_data.hours_units);
                    check_field("hours_tens", want.hours_tens, o_out_data.hours_tens);
                    check_field("rtc_write", want.rtc_write, o_out_data.rtc_write);
                    results_checked++;
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved       = 1'b1;
                in_accepted = 1'b1;
                want        = predict_clock_step(i_in_data);
                expected_readings.push_back(want);
                if (want.rtc_write) set_steps++;
                if (t_mode'(i_in_data.mode) == MODE_LOAD) loads_seen++;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // Watchdog: end the run when nothing has transferred for too long
    initial begin
        wait (idle_cycles >= WATCHDOG_CYCLES);
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        #1;

        // Directed: invalid digits, ignored pins and waves, rollover, clamping
        queue_sample(MODE_LOAD, 1'b0, 2'b11, 7'h7F, 7'h7F, 6'h3F);
        queue_sample(MODE_RUN, 1'b1, 2'b11, 7'h00, 7'h00, 6'h00);
        queue_sample(MODE_RUN, 1'b0, 2'b00, 7'h7F, 7'h7F, 6'h3F);
        queue_sample(MODE_LOAD, 1'b1, 2'b00, 7'h59, 7'h59, 6'h23);
        queue_sample(MODE_SET_SUNIT, 1'b1, 2'b11, 7'h00, 7'h00, 6'h00);
        queue_sample(MODE_RUN, 1'b1, 2'b11, 7'h00, 7'h00, 6'h00);
        queue_detent(MODE_SET_HTENS, 1'b1);
        queue_detent(MODE_SET_MTENS, 1'b0);
        queue_sample(MODE_LOAD, 1'b0, 2'b10, 7'h00, 7'h00, 6'h3F);
        queue_detent(MODE_SET_HUNIT, 1'b1);
        queue_sample(MODE_SET_MUNIT, 1'b0, 2'b01, 7'h00, 7'h00, 6'h00);
        queue_sample(MODE_SET_STENS, 1'b1, 2'b11, 7'h00, 7'h00, 6'h00);
        queue_sample(MODE_LOAD, 1'b0, 2'b11, 7'h00, 7'h00, 6'h00);

        // Random phases; each ends with the sender paused until all results are in
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            send_idle_pct  = SEND_IDLE_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            queue_random_phase(PHASE_ITEMS);
            if (ph == NUM_PHASES - 1) long_holds_wanted++;
            wait_drained();
        end

        repeat (4) @(posedge i_clk);
        $display("Sent %0d samples over %0d phases: %0d loads, %0d encoder set steps.",
                 samples_queued, NUM_PHASES, loads_seen, set_steps);
        $display("Checked %0d time readings with %0d mismatches.", results_checked, mismatches);
        if (mismatches == 0 && expected_readings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
